// ----- rtl/core/mau_pkg.sv -----
// Shared constants, operation codes and control types of the modular arithmetic unit.
package mau_pkg;

    localparam int RESIDUE_BITS_DEF  = 31;
    localparam int EXPONENT_BITS_DEF = 63;
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // Request modes carried on the mode port.
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_NEG = 3'd4;
    localparam logic [2:0] MODE_POW = 3'd5;
    localparam logic [2:0] MODE_INV = 3'd6;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        UOP_REM = 2'd0,
        UOP_MUL = 2'd1,
        UOP_ADD = 2'd2,
        UOP_SUB = 2'd3
    } uop_t;

    typedef struct packed {
        logic start;
        uop_t op;
    } ucmd_t;

endpackage

// ----- rtl/core/mau_alu.sv -----
// Shared iterative unit: remainder/quotient, modular multiply, modular add and subtract.
module mau_alu #(
    parameter int W = mau_pkg::RESIDUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mau_pkg::ucmd_t cmd,
    input  logic [W-1:0]  x,
    input  logic [W-1:0]  y,
    input  logic [W-1:0]  m,
    output logic          done,
    output logic [W-1:0]  res,
    output logic [W-1:0]  quo
);
    import mau_pkg::*;

    localparam int CW = $clog2(W + 1);

    uop_t          op_reg;
    logic [W-1:0]  acc_reg, add_reg, sh_reg, cmp_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          phase_reg, run_reg, done_reg;

    logic [W-1:0]  addend;
    logic          cin;
    logic [W:0]    sum, nxt;
    logic          ge, last;

    // One adder and one compare-subtract serve every operation.
    always_comb
    begin
        addend = acc_reg;
        cin    = 1'b0;
        case (op_reg)
            UOP_REM:
            begin
                addend = acc_reg;
                cin    = sh_reg[W-1];
            end
            UOP_MUL:
            begin
                if (phase_reg)
                    addend = sh_reg[W-1] ? add_reg : '0;
                else
                    addend = acc_reg;
            end
            UOP_ADD, UOP_SUB:
            begin
                addend = add_reg;
            end
            default:
            begin
                addend = acc_reg;
            end
        endcase
        sum  = {1'b0, acc_reg} + {1'b0, addend} + {{W{1'b0}}, cin};
        ge   = (sum >= {1'b0, cmp_reg});
        nxt  = ge ? (sum - {1'b0, cmp_reg}) : sum;
        last = (cnt_reg == CW'(1)) && ((op_reg != UOP_MUL) || phase_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            op_reg    <= UOP_REM;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                op_reg    <= cmd.op;
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
                case (cmd.op)
                    UOP_REM, UOP_MUL: cnt_reg <= CW'(W);
                    default:          cnt_reg <= CW'(1);
                endcase
            end
            else if (run_reg)
            begin
                if (op_reg == UOP_MUL)
                    phase_reg <= !phase_reg;
                if ((op_reg != UOP_MUL) || phase_reg)
                    cnt_reg <= cnt_reg - CW'(1);
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= '0;
            case (cmd.op)
                UOP_REM:
                begin
                    acc_reg <= '0;
                    sh_reg  <= x;
                    cmp_reg <= y;
                    add_reg <= '0;
                end
                UOP_MUL:
                begin
                    acc_reg <= '0;
                    sh_reg  <= y;
                    add_reg <= x;
                    cmp_reg <= m;
                end
                UOP_ADD:
                begin
                    acc_reg <= x;
                    add_reg <= y;
                    sh_reg  <= '0;
                    cmp_reg <= m;
                end
                default:
                begin
                    acc_reg <= x;
                    add_reg <= m - y;
                    sh_reg  <= '0;
                    cmp_reg <= m;
                end
            endcase
        end
        else if (run_reg)
        begin
            acc_reg <= nxt[W-1:0];
            if (op_reg == UOP_REM)
            begin
                quo_reg <= {quo_reg[W-2:0], ge};
                sh_reg  <= {sh_reg[W-2:0], 1'b0};
            end
            else if ((op_reg == UOP_MUL) && phase_reg)
            begin
                sh_reg <= {sh_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/core/modular_arithmetic_unit_top.sv -----
// Top level of the modular arithmetic unit: request sequencer around the shared unit.
//
//  Channel   Direction  Handshake                 Beat contents
//  request   in         start while busy is low   mode, operand_a, operand_b, exponent
//  result    out        result_valid strobe       result
//  modulus   in         modulus_we                modulus_wdata
//
// One request is worked on at a time; busy stays high until its result beat.
// Each shared-unit operation has an issue step, its run and a done step.
// Both operands are reduced first, each through the shared unit.
// Add, subtract and negate then take one more shared-unit operation, as does multiply.
// Power does a modular multiply per set exponent bit and a square per bit, with a
// check per bit; inverse and divide repeat divide, multiply, subtract per Euclid step.
// The result beat lasts one cycle and cannot be held off by the receiver.
// Reset is asynchronous and active low; it loads the modulus with 1000000007.
module modular_arithmetic_unit_top #(
    parameter int RESIDUE_BITS  = mau_pkg::RESIDUE_BITS_DEF,
    parameter int EXPONENT_BITS = mau_pkg::EXPONENT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               mode,
    input  logic [RESIDUE_BITS-1:0]  operand_a,
    input  logic [RESIDUE_BITS-1:0]  operand_b,
    input  logic [EXPONENT_BITS-1:0] exponent,
    input  logic                     modulus_we,
    input  logic [RESIDUE_BITS-1:0]  modulus_wdata,
    output logic                     result_valid,
    output logic [RESIDUE_BITS-1:0]  result
);
    import mau_pkg::*;

    localparam int W = RESIDUE_BITS;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_RED_A   = 13'b0000000000010,
        S_RED_B   = 13'b0000000000100,
        S_ARITH   = 13'b0000000001000,
        S_POW_CHK = 13'b0000000010000,
        S_POW_MR  = 13'b0000000100000,
        S_POW_SQ  = 13'b0000001000000,
        S_EU_CHK  = 13'b0000010000000,
        S_EU_DIV  = 13'b0000100000000,
        S_EU_QY   = 13'b0001000000000,
        S_EU_SUB  = 13'b0010000000000,
        S_FIN_MUL = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     issued_reg;
    logic [W-1:0]             modulus_reg;
    logic [2:0]               mode_reg;
    logic [W-1:0]             opa_reg, opb_reg;
    logic [EXPONENT_BITS-1:0] e_reg;
    logic [W-1:0]             a_reg, b_reg, r_reg;
    logic [W-1:0]             ea_reg, eb_reg, ex_reg, ey_reg, q_reg;

    ucmd_t                    ucmd;
    logic [W-1:0]             ux, uy;
    logic                     udone;
    logic [W-1:0]             ures, uquo;
    logic                     working;
    logic [W-1:0]             one_m;

    // One in residue form; zero when the modulus is one.
    assign one_m = (modulus_reg == W'(1)) ? '0 : W'(1);

    mau_alu #(.W(W)) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ucmd),
        .x     (ux),
        .y     (uy),
        .m     (modulus_reg),
        .done  (udone),
        .res   (ures),
        .quo   (uquo)
    );

    // States that hand one operation to the shared unit and wait for it.
    assign working = (state_reg != S_IDLE) && (state_reg != S_DONE) &&
                     (state_reg != S_POW_CHK) && (state_reg != S_EU_CHK);

    always_comb
    begin
        ucmd.start = working && !issued_reg;
        ucmd.op    = UOP_REM;
        ux         = '0;
        uy         = '0;
        case (state_reg)
            S_RED_A:
            begin
                ux = opa_reg;
                uy = modulus_reg;
            end
            S_RED_B:
            begin
                ux = opb_reg;
                uy = modulus_reg;
            end
            S_ARITH:
            begin
                ux = a_reg;
                uy = b_reg;
                if (mode_reg == MODE_ADD)
                    ucmd.op = UOP_ADD;
                else if (mode_reg == MODE_MUL)
                    ucmd.op = UOP_MUL;
                else if (mode_reg == MODE_NEG)
                begin
                    ucmd.op = UOP_SUB;
                    ux      = '0;
                    uy      = a_reg;
                end
                else
                    ucmd.op = UOP_SUB;
            end
            S_POW_MR:
            begin
                ucmd.op = UOP_MUL;
                ux      = r_reg;
                uy      = a_reg;
            end
            S_POW_SQ:
            begin
                ucmd.op = UOP_MUL;
                ux      = a_reg;
                uy      = a_reg;
            end
            S_EU_DIV:
            begin
                ux = ea_reg;
                uy = eb_reg;
            end
            S_EU_QY:
            begin
                ucmd.op = UOP_MUL;
                ux      = q_reg;
                uy      = ey_reg;
            end
            S_EU_SUB:
            begin
                ucmd.op = UOP_SUB;
                ux      = ex_reg;
                uy      = ures;
            end
            S_FIN_MUL:
            begin
                ucmd.op = UOP_MUL;
                ux      = a_reg;
                uy      = ex_reg;
            end
            default:
            begin
                ucmd.op = UOP_REM;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((modulus_reg == '0) || (mode > MODE_INV))
                        state_next = S_DONE;
                    else
                        state_next = S_RED_A;
                end
            end
            S_RED_A:
            begin
                if (udone)
                    state_next = S_RED_B;
            end
            S_RED_B:
            begin
                if (udone)
                begin
                    if (mode_reg == MODE_POW)
                        state_next = S_POW_CHK;
                    else if ((mode_reg == MODE_DIV) || (mode_reg == MODE_INV))
                        state_next = S_EU_CHK;
                    else
                        state_next = S_ARITH;
                end
            end
            S_ARITH, S_FIN_MUL:
            begin
                if (udone)
                    state_next = S_DONE;
            end
            S_POW_CHK:
            begin
                if (e_reg == '0)
                    state_next = S_DONE;
                else if (e_reg[0])
                    state_next = S_POW_MR;
                else
                    state_next = S_POW_SQ;
            end
            S_POW_MR:
            begin
                if (udone)
                    state_next = S_POW_SQ;
            end
            S_POW_SQ:
            begin
                if (udone)
                    state_next = S_POW_CHK;
            end
            S_EU_CHK:
            begin
                if (eb_reg != '0)
                    state_next = S_EU_DIV;
                else if (mode_reg == MODE_DIV)
                    state_next = S_FIN_MUL;
                else
                    state_next = S_DONE;
            end
            S_EU_DIV:
            begin
                if (udone)
                    state_next = S_EU_QY;
            end
            S_EU_QY:
            begin
                if (udone)
                    state_next = S_EU_SUB;
            end
            S_EU_SUB:
            begin
                if (udone)
                    state_next = S_EU_CHK;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            modulus_reg <= W'(MODULUS_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (ucmd.start)
                issued_reg <= 1'b1;
            else if (udone)
                issued_reg <= 1'b0;
            if (modulus_we)
                modulus_reg <= modulus_wdata;
        end
    end

    // Operand and working registers; the sequencer decides when each loads.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_reg <= mode;
                    opa_reg  <= operand_a;
                    opb_reg  <= operand_b;
                    e_reg    <= exponent;
                    r_reg    <= '0;
                end
            end
            S_RED_A:
            begin
                if (udone)
                    a_reg <= ures;
            end
            S_RED_B:
            begin
                if (udone)
                begin
                    b_reg  <= ures;
                    r_reg  <= one_m;
                    ea_reg <= (mode_reg == MODE_DIV) ? ures : a_reg;
                    eb_reg <= modulus_reg;
                    ex_reg <= one_m;
                    ey_reg <= '0;
                end
            end
            S_ARITH, S_FIN_MUL:
            begin
                if (udone)
                    r_reg <= ures;
            end
            S_POW_MR:
            begin
                if (udone)
                    r_reg <= ures;
            end
            S_POW_SQ:
            begin
                if (udone)
                begin
                    a_reg <= ures;
                    e_reg <= e_reg >> 1;
                end
            end
            S_EU_CHK:
            begin
                if ((eb_reg == '0) && (mode_reg == MODE_INV))
                    r_reg <= ex_reg;
            end
            S_EU_DIV:
            begin
                if (udone)
                begin
                    q_reg  <= uquo;
                    ea_reg <= eb_reg;
                    eb_reg <= ures;
                end
            end
            S_EU_SUB:
            begin
                if (udone)
                begin
                    ex_reg <= ey_reg;
                    ey_reg <= ures;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign result       = r_reg;

endmodule

// ----- rtl/core/mau_checker.sv -----
// Port-level checker of the modular arithmetic unit, bound to its top level.
module mau_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat outside a request");

    a_end_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid))
        else $error("busy dropped without a result beat");

endmodule

bind modular_arithmetic_unit_top mau_checker u_mau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid)
);
